// File: hdl/polynomial_syntax_recognizer_assert.svh
// ---------------------------------------------------------------------------
// polynomial syntax recognizer assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef POLYNOMIAL_SYNTAX_RECOGNIZER_ASSERT_SVH
`define POLYNOMIAL_SYNTAX_RECOGNIZER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psr assertion failed");

// next-cycle implication
`define PSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psr assertion failed");

`else

`define PSR_ASSERT_IMP(label, ante, cons)
`define PSR_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: hdl/psr_pkg.sv
// ---------------------------------------------------------------------------
// psr_pkg
// shared beat types, result codes and character constants
// ---------------------------------------------------------------------------
package psr_pkg;

  // character constants
  localparam logic [7:0] ChrX       = 8'h58;
  localparam logic [7:0] ChrCaret   = 8'h5E;
  localparam logic [7:0] ChrStar    = 8'h2A;
  localparam logic [7:0] ChrPoint   = 8'h2E;
  localparam logic [7:0] ChrPlus    = 8'h2B;
  localparam logic [7:0] ChrMinus   = 8'h2D;
  localparam logic [7:0] ChrSpace   = 8'h20;
  localparam logic [7:0] ChrTab     = 8'h09;
  localparam logic [7:0] ChrNewline = 8'h0A;
  localparam logic [7:0] ChrZero    = 8'h30;
  localparam logic [7:0] ChrNine    = 8'h39;

  typedef enum logic [1:0] {
    V_PENDING = 2'd0,
    V_ACCEPT  = 2'd1,
    V_REJECT  = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_DIGIT    = 3'd1,
    E_X        = 3'd2,
    E_TERM     = 3'd3,
    E_TRAILING = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    verdict_e verdict;
    err_e     error_kind;
  } out_beat_t;

  // decoded character classes, all low except eof at end of input
  typedef struct packed {
    logic eof;
    logic blank;
    logic digit;
    logic is_x;
    logic caret;
    logic star;
    logic point;
    logic sign;
    logic minus;
    logic newline;
  } char_class_t;

endpackage

// File: hdl/psr_classify.sv
// ---------------------------------------------------------------------------
// psr_classify
// decodes one input beat into character class flags
// ---------------------------------------------------------------------------
module psr_classify (
  input  psr_pkg::in_beat_t    beat_i,
  output psr_pkg::char_class_t class_o
);
  import psr_pkg::*;

  logic [7:0] ch;
  logic       chr;

  assign ch  = beat_i.character;
  assign chr = !beat_i.end_of_input;

  // class flags, masked at end of input
  always_comb begin
    class_o         = '0;
    class_o.eof     = beat_i.end_of_input;
    class_o.blank   = chr && (ch == ChrSpace || ch == ChrTab);
    class_o.digit   = chr && (ch >= ChrZero) && (ch <= ChrNine);
    class_o.is_x    = chr && (ch == ChrX);
    class_o.caret   = chr && (ch == ChrCaret);
    class_o.star    = chr && (ch == ChrStar);
    class_o.point   = chr && (ch == ChrPoint);
    class_o.sign    = chr && (ch == ChrPlus || ch == ChrMinus);
    class_o.minus   = chr && (ch == ChrMinus);
    class_o.newline = chr && (ch == ChrNewline);
  end

endmodule

// File: hdl/psr_parser.sv
// ---------------------------------------------------------------------------
// psr_parser
// parse position register, transition logic and result register
// ---------------------------------------------------------------------------
module psr_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  psr_pkg::char_class_t class_i,
  output psr_pkg::out_beat_t   result_o
);
  import psr_pkg::*;

  typedef enum logic [3:0] {
    P_START     = 4'd0,
    P_TERM      = 4'd1,
    P_INT       = 4'd2,
    P_AFTER_INT = 4'd3,
    P_FRAC      = 4'd4,
    P_AFTER_NUM = 4'd5,
    P_STAR      = 4'd6,
    P_AFTER_X   = 4'd7,
    P_CARET     = 4'd8,
    P_EXP       = 4'd9,
    P_AFTER_EXP = 4'd10
  } pos_e;

  pos_e      pos_q, pos_d;
  out_beat_t result_q, result_d;

  // outcome of a character after a complete term
  pos_e      at_pos;
  out_beat_t at_res;
  // outcome of a character that must begin a term
  pos_e      ts_pos;
  out_beat_t ts_res;

  always_comb begin
    at_pos = P_START;
    at_res = '{verdict: V_PENDING, error_kind: E_NONE};
    if (class_i.eof || class_i.newline) begin
      at_res.verdict = V_ACCEPT;
    end else if (class_i.sign) begin
      at_pos = P_TERM;
    end else begin
      at_res = '{verdict: V_REJECT, error_kind: E_TRAILING};
    end
  end

  always_comb begin
    ts_pos = P_START;
    ts_res = '{verdict: V_PENDING, error_kind: E_NONE};
    if (class_i.is_x) begin
      ts_pos = P_AFTER_X;
    end else if (class_i.digit) begin
      ts_pos = P_INT;
    end else begin
      ts_res = '{verdict: V_REJECT, error_kind: E_TERM};
    end
  end

  // transition for the current beat
  always_comb begin
    pos_d    = pos_q;
    result_d = '{verdict: V_PENDING, error_kind: E_NONE};
    unique case (pos_q)
      P_TERM: begin
        if (!class_i.blank) begin
          pos_d    = ts_pos;
          result_d = ts_res;
        end
      end
      P_INT, P_AFTER_INT: begin
        if (class_i.digit && pos_q == P_INT) begin
          pos_d = P_INT;
        end else if (class_i.blank) begin
          pos_d = P_AFTER_INT;
        end else if (class_i.point) begin
          pos_d = P_FRAC;
        end else if (class_i.star) begin
          pos_d = P_STAR;
        end else begin
          pos_d    = at_pos;
          result_d = at_res;
        end
      end
      P_FRAC, P_AFTER_NUM: begin
        if (class_i.digit && pos_q == P_FRAC) begin
          pos_d = P_FRAC;
        end else if (class_i.blank) begin
          pos_d = P_AFTER_NUM;
        end else if (class_i.star) begin
          pos_d = P_STAR;
        end else begin
          pos_d    = at_pos;
          result_d = at_res;
        end
      end
      P_STAR: begin
        if (!class_i.blank) begin
          if (class_i.is_x) begin
            pos_d = P_AFTER_X;
          end else begin
            pos_d    = P_START;
            result_d = '{verdict: V_REJECT, error_kind: E_X};
          end
        end
      end
      P_AFTER_X: begin
        if (!class_i.blank) begin
          if (class_i.caret) begin
            pos_d = P_CARET;
          end else begin
            pos_d    = at_pos;
            result_d = at_res;
          end
        end
      end
      P_CARET: begin
        if (!class_i.blank) begin
          if (class_i.digit) begin
            pos_d = P_EXP;
          end else begin
            pos_d    = P_START;
            result_d = '{verdict: V_REJECT, error_kind: E_DIGIT};
          end
        end
      end
      P_EXP, P_AFTER_EXP: begin
        if (class_i.digit && pos_q == P_EXP) begin
          pos_d = P_EXP;
        end else if (class_i.blank) begin
          pos_d = P_AFTER_EXP;
        end else begin
          pos_d    = at_pos;
          result_d = at_res;
        end
      end
      default: begin
        // start of polynomial, unused codes behave the same
        if (class_i.blank) begin
          pos_d = pos_q;
        end else if (class_i.minus) begin
          pos_d = P_TERM;
        end else begin
          pos_d    = ts_pos;
          result_d = ts_res;
        end
      end
    endcase
  end

  // parse position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= P_START;
    end else if (step_i) begin
      pos_q <= pos_d;
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// File: hdl/polynomial_syntax_recognizer.sv
// ---------------------------------------------------------------------------
// polynomial_syntax_recognizer
// checks a character stream, line by line, against a polynomial grammar
// ---------------------------------------------------------------------------
// usage:
//   input channel: in_beat_i carries one character or an end-of-input
//   flag, taken when in_valid_i is high and in_stall_o is low.
//   output channel: out_beat_o carries verdict and error_kind, taken
//   when out_valid_o is high and out_stall_i is low.
//   every input beat yields exactly one output beat, in order.
//   the beat sits in the input register and then passes through the parse
//   logic into the result register, out_valid_o rising with the result.
//   throughput: one beat per cycle while out_stall_i is low; the parse
//   state updates between the input register and the result register.
//   when out_stall_i holds, the result waits in the output register and
//   one more beat is held in the input register; in_stall_o then rises.
//   reset clears both valid flags and returns the parser to the start
//   of a polynomial; after an accept or reject verdict the parser also
//   restarts for the next line.
// ---------------------------------------------------------------------------
`include "polynomial_syntax_recognizer_assert.svh"

module polynomial_syntax_recognizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  psr_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output psr_pkg::out_beat_t out_beat_o
);
  import psr_pkg::*;

  logic        in_valid_q, in_valid_d;
  in_beat_t    in_beat_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        step;
  logic        in_take;
  char_class_t cls;

  // handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_beat_q <= in_beat_i;
    end
  end

  psr_classify u_classify (
    .beat_i  (in_beat_q),
    .class_o (cls)
  );

  psr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .class_i  (cls),
    .result_o (out_beat_o)
  );

  assign out_valid_o = out_valid_q;

  // checks
  `PSR_ASSERT_NXT(a_step_gives_result, step, out_valid_o)
  `PSR_ASSERT_IMP(a_stall_only_when_full, in_stall_o, in_valid_q && out_valid_q)
  `PSR_ASSERT_IMP(a_kind_none_unless_reject, out_valid_o && out_beat_o.verdict != V_REJECT, out_beat_o.error_kind == E_NONE)
  `PSR_ASSERT_IMP(a_reject_has_kind, out_valid_o && out_beat_o.verdict == V_REJECT, out_beat_o.error_kind != E_NONE)

endmodule
